// ----- sv/indexed_doubly_linked_list_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the indexed doubly linked list
// Concurrent checks that are compiled for simulation and left empty for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property that holds in the same cycle.
`define IDLL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Consequent that must hold in the cycle after the antecedent.
`define IDLL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define IDLL_ASSERT(lbl, clk, rstn, prop, msg)
`define IDLL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- sv/idll_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed doubly linked list package
// Request codes, port widths and the word formats passed between the parts.
// ----------------------------------------------------------------------------
package idll_pkg;

    localparam int REQ_W  = 3;
    localparam int IDX_W  = 10;
    localparam int PIDX_W = 11;
    localparam int VAL_W  = 32;

    localparam logic [REQ_W-1:0] OP_LOAD       = 3'd0;
    localparam logic [REQ_W-1:0] OP_ENDS       = 3'd1;
    localparam logic [REQ_W-1:0] OP_INS_AFTER  = 3'd2;
    localparam logic [REQ_W-1:0] OP_INS_BEFORE = 3'd3;
    localparam logic [REQ_W-1:0] OP_DELETE     = 3'd4;

    // Index as it arrives on a port, already checked against the store size.
    typedef struct packed {
        logic             none;
        logic [IDX_W-1:0] idx;
    } t_idx;

    typedef struct packed {
        logic [REQ_W-1:0]  op;
        t_idx              node;
        logic [VAL_W-1:0]  value;
        t_idx              link_next;
        t_idx              link_prev;
        t_idx              head;
        t_idx              tail;
        logic [PIDX_W-1:0] free;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] new_index;
        logic [VAL_W-1:0] removed_value;
        logic             status;
    } t_res;

endpackage

// ----- sv/idll_fifo.sv -----
// ----------------------------------------------------------------------------
// Small word queue
// Register-based first-in first-out buffer with push/full and pop/empty.
// ----------------------------------------------------------------------------
module idll_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- sv/idll_front.sv -----
// ----------------------------------------------------------------------------
// List request decoder
// Checks indices against the store size, clamps the free pointer and drops
// requests that have no effect.
// ----------------------------------------------------------------------------
module idll_front #(
    parameter int NODE_COUNT = 1024
) (
    input  logic [idll_pkg::REQ_W-1:0]  i_req_type,
    input  logic [idll_pkg::PIDX_W-1:0] i_node_index,
    input  logic [idll_pkg::VAL_W-1:0]  i_item_value,
    input  logic [idll_pkg::PIDX_W-1:0] i_link_next,
    input  logic [idll_pkg::PIDX_W-1:0] i_link_prev,
    input  logic [idll_pkg::PIDX_W-1:0] i_head_index,
    input  logic [idll_pkg::PIDX_W-1:0] i_tail_index,
    input  logic [idll_pkg::PIDX_W-1:0] i_free_start,
    output logic                        o_keep,
    output idll_pkg::t_cmd              o_cmd
);

    // Negative or out-of-store indices become "no node".
    function automatic idll_pkg::t_idx to_idx(input logic [idll_pkg::PIDX_W-1:0] raw);
        idll_pkg::t_idx r;
        r.idx  = raw[idll_pkg::IDX_W-1:0];
        r.none = raw[idll_pkg::PIDX_W-1] ||
                 (32'(raw[idll_pkg::IDX_W-1:0]) >= NODE_COUNT);
        return r;
    endfunction

    always_comb begin
        o_cmd.op        = i_req_type;
        o_cmd.node      = to_idx(i_node_index);
        o_cmd.value     = i_item_value;
        o_cmd.link_next = to_idx(i_link_next);
        o_cmd.link_prev = to_idx(i_link_prev);
        o_cmd.head      = to_idx(i_head_index);
        o_cmd.tail      = to_idx(i_tail_index);
        o_cmd.free      = (32'(i_free_start) > NODE_COUNT) ?
                          idll_pkg::PIDX_W'(NODE_COUNT) : i_free_start;

        unique case (i_req_type) inside
            idll_pkg::OP_LOAD: begin
                o_keep = !o_cmd.node.none;
            end
            idll_pkg::OP_ENDS, idll_pkg::OP_INS_AFTER, idll_pkg::OP_INS_BEFORE,
            idll_pkg::OP_DELETE: begin
                o_keep = 1'b1;
            end
            default: begin
                o_keep = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/idll_back.sv -----
// ----------------------------------------------------------------------------
// List update engine
// Owns the node store, head, tail and free pointer, and carries out one
// request at a time as a read, a write and an optional link fix-up write.
// ----------------------------------------------------------------------------
`include "indexed_doubly_linked_list_top_assert.svh"

module idll_back #(
    parameter int NODE_COUNT = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  idll_pkg::t_cmd i_cmd,
    input  logic           i_res_full,
    output logic           o_res_push,
    output idll_pkg::t_res o_res
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int LW = IW + 1;
    localparam int FW = IW + 1;
    localparam logic [FW-1:0] FREE_MAX  = FW'(NODE_COUNT);
    localparam logic [LW-1:0] LINK_NONE = {1'b1, {IW{1'b0}}};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_WR1  = 2'd2;
    localparam logic [1:0] S_WR2  = 2'd3;

    // A stored link is a "none" flag above the entry index.
    function automatic logic [LW-1:0] to_link(input idll_pkg::t_idx x);
        return x.none ? LINK_NONE : {1'b0, IW'(x.idx)};
    endfunction

    logic [1:0]           r_state, n_state;
    idll_pkg::t_cmd       r_cmd;
    logic [LW-1:0]        r_head, n_head;
    logic [LW-1:0]        r_tail, n_tail;
    logic [FW-1:0]        r_free, n_free;
    logic [IW-1:0]        r_n, n_n;
    logic                 r_fix_next_en, n_fix_next_en;
    logic                 r_fix_prev_en, n_fix_prev_en;
    logic [IW-1:0]        r_fix_next_addr, n_fix_next_addr;
    logic [IW-1:0]        r_fix_prev_addr, n_fix_prev_addr;

    logic [idll_pkg::VAL_W-1:0] mem_val  [NODE_COUNT];
    logic [LW-1:0]              mem_next [NODE_COUNT];
    logic [LW-1:0]              mem_prev [NODE_COUNT];
    logic [idll_pkg::VAL_W-1:0] r_rd_val;
    logic [LW-1:0]              r_rd_next;
    logic [LW-1:0]              r_rd_prev;

    logic                       we_val, we_next, we_prev;
    logic [IW-1:0]              wa_val, wa_next, wa_prev;
    logic [idll_pkg::VAL_W-1:0] wd_val;
    logic [LW-1:0]              wd_next, wd_prev;

    logic [LW-1:0] w_anchor;
    logic          w_anchor_none;
    logic [IW-1:0] w_anchor_addr;
    logic          w_full;
    logic [IW-1:0] w_n;
    logic [LW-1:0] w_n_link;
    logic [LW-1:0] w_x_after;
    logic [LW-1:0] w_x_before;

    assign w_anchor      = to_link(r_cmd.node);
    assign w_anchor_none = w_anchor[LW-1];
    assign w_anchor_addr = w_anchor[IW-1:0];
    assign w_full        = (r_free >= FREE_MAX);
    assign w_n           = r_free[IW-1:0];
    assign w_n_link      = {1'b0, w_n};
    // An anchor equal to the new entry sees the freshly cleared links.
    assign w_x_after     = (w_anchor_addr == w_n) ? LINK_NONE : r_rd_next;
    assign w_x_before    = (w_anchor_addr == w_n) ? LINK_NONE : r_rd_prev;

    always_comb begin
        n_state         = r_state;
        n_head          = r_head;
        n_tail          = r_tail;
        n_free          = r_free;
        n_n             = r_n;
        n_fix_next_en   = r_fix_next_en;
        n_fix_prev_en   = r_fix_prev_en;
        n_fix_next_addr = r_fix_next_addr;
        n_fix_prev_addr = r_fix_prev_addr;
        we_val          = 1'b0;
        we_next         = 1'b0;
        we_prev         = 1'b0;
        wa_val          = w_anchor_addr;
        wa_next         = w_anchor_addr;
        wa_prev         = w_anchor_addr;
        wd_val          = r_cmd.value;
        wd_next         = LINK_NONE;
        wd_prev         = LINK_NONE;
        o_cmd_pop       = 1'b0;
        o_res_push      = 1'b0;
        o_res           = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_READ: begin
                n_state = S_WR1;
            end
            S_WR1: begin
                n_state = S_IDLE;
                unique case (r_cmd.op) inside
                    idll_pkg::OP_LOAD: begin
                        we_val  = 1'b1;
                        we_next = 1'b1;
                        we_prev = 1'b1;
                        wd_next = to_link(r_cmd.link_next);
                        wd_prev = to_link(r_cmd.link_prev);
                    end
                    idll_pkg::OP_ENDS: begin
                        n_head = to_link(r_cmd.head);
                        n_tail = to_link(r_cmd.tail);
                        n_free = FW'(r_cmd.free);
                    end
                    idll_pkg::OP_INS_AFTER, idll_pkg::OP_INS_BEFORE: begin
                        if (w_full) begin
                            o_res_push = 1'b1;
                            o_res.status = 1'b1;
                        end else begin
                            n_state = S_WR2;
                            n_n     = w_n;
                            n_free  = r_free + 1'b1;
                            we_val  = 1'b1;
                            we_next = 1'b1;
                            we_prev = 1'b1;
                            wa_val  = w_n;
                            wa_next = w_n;
                            wa_prev = w_n;
                            if (r_cmd.op == idll_pkg::OP_INS_AFTER) begin
                                if (w_anchor_none) begin
                                    wd_next         = r_head;
                                    n_fix_next_en   = 1'b0;
                                    n_fix_prev_en   = !r_head[LW-1];
                                    n_fix_prev_addr = r_head[IW-1:0];
                                    n_head          = w_n_link;
                                    if (r_tail[LW-1]) begin
                                        n_tail = w_n_link;
                                    end
                                end else begin
                                    wd_next         = w_x_after;
                                    wd_prev         = w_anchor;
                                    n_fix_prev_en   = !w_x_after[LW-1];
                                    n_fix_prev_addr = w_x_after[IW-1:0];
                                    n_fix_next_en   = 1'b1;
                                    n_fix_next_addr = w_anchor_addr;
                                    if (w_x_after[LW-1]) begin
                                        n_tail = w_n_link;
                                    end
                                end
                            end else begin
                                if (w_anchor_none) begin
                                    wd_prev         = r_tail;
                                    n_fix_prev_en   = 1'b0;
                                    n_fix_next_en   = !r_tail[LW-1];
                                    n_fix_next_addr = r_tail[IW-1:0];
                                    n_tail          = w_n_link;
                                    if (r_head[LW-1]) begin
                                        n_head = w_n_link;
                                    end
                                end else begin
                                    wd_prev         = w_x_before;
                                    wd_next         = w_anchor;
                                    n_fix_next_en   = !w_x_before[LW-1];
                                    n_fix_next_addr = w_x_before[IW-1:0];
                                    n_fix_prev_en   = 1'b1;
                                    n_fix_prev_addr = w_anchor_addr;
                                    if (w_x_before[LW-1]) begin
                                        n_head = w_n_link;
                                    end
                                end
                            end
                        end
                    end
                    idll_pkg::OP_DELETE: begin
                        o_res_push = 1'b1;
                        if (!w_anchor_none) begin
                            o_res.removed_value = r_rd_val;
                            // Splice the neighbors around the removed entry.
                            if (!r_rd_prev[LW-1]) begin
                                we_next = 1'b1;
                                wa_next = r_rd_prev[IW-1:0];
                                wd_next = r_rd_next;
                            end else begin
                                n_head = r_rd_next;
                            end
                            if (!r_rd_next[LW-1]) begin
                                we_prev = 1'b1;
                                wa_prev = r_rd_next[IW-1:0];
                                wd_prev = r_rd_prev;
                            end else begin
                                n_tail = r_rd_prev;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WR2: begin
                // Point the neighbors at the new entry.
                n_state         = S_IDLE;
                we_next         = r_fix_next_en;
                wa_next         = r_fix_next_addr;
                wd_next         = {1'b0, r_n};
                we_prev         = r_fix_prev_en;
                wa_prev         = r_fix_prev_addr;
                wd_prev         = {1'b0, r_n};
                o_res_push      = 1'b1;
                o_res.new_index = idll_pkg::IDX_W'(r_n);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= LINK_NONE;
            r_tail  <= LINK_NONE;
            r_free  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        r_n             <= n_n;
        r_fix_next_en   <= n_fix_next_en;
        r_fix_prev_en   <= n_fix_prev_en;
        r_fix_next_addr <= n_fix_next_addr;
        r_fix_prev_addr <= n_fix_prev_addr;
    end

    always_ff @(posedge i_clk) begin
        if (we_val) begin
            mem_val[wa_val] <= wd_val;
        end
        r_rd_val <= mem_val[w_anchor_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_next) begin
            mem_next[wa_next] <= wd_next;
        end
        r_rd_next <= mem_next[w_anchor_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_prev) begin
            mem_prev[wa_prev] <= wd_prev;
        end
        r_rd_prev <= mem_prev[w_anchor_addr];
    end

    `IDLL_ASSERT(a_push_room, i_clk, i_rst_n, o_res_push |-> !i_res_full, "result pushed into full queue")
    `IDLL_ASSERT(a_free_bound, i_clk, i_rst_n, r_free <= FREE_MAX, "free pointer beyond store size")
    `IDLL_ASSERT_NEXT(a_pop_reads, i_clk, i_rst_n, o_cmd_pop, r_state == S_READ, "pop did not start a read")
    `IDLL_ASSERT_NEXT(a_fix_ends, i_clk, i_rst_n, r_state == S_WR2, r_state == S_IDLE, "fix-up did not end")

endmodule

// ----- sv/indexed_doubly_linked_list_top.sv -----
// ----------------------------------------------------------------------------
// Indexed doubly linked list
// Array-based doubly linked list with load, set-ends, insert and delete.
// ----------------------------------------------------------------------------
// Results: a delete, or an insert into a full store, pushes its result word
// from the node-write state; any other insert from the link fix-up state.
// The engine takes an insert through idle, read, node write and link fix-up,
// and other words through idle, read and node write; dropped ones cost nothing.
// Reset is synchronous: both queues empty, head and tail none, free pointer
// zero. The node store is not cleared; entries hold garbage until written.
module indexed_doubly_linked_list_top #(
    parameter int NODE_COUNT = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_req_type,
    input  logic signed [10:0] i_node_index,
    input  logic signed [31:0] i_item_value,
    input  logic signed [10:0] i_link_next,
    input  logic signed [10:0] i_link_prev,
    input  logic signed [10:0] i_head_index,
    input  logic signed [10:0] i_tail_index,
    input  logic [10:0]        i_free_start,
    output logic               empty,
    input  logic               pop,
    output logic [9:0]         o_new_index,
    output logic signed [31:0] o_removed_value,
    output logic               o_status
);

    // Decoded request word from the front decoder.
    idll_pkg::t_cmd w_front_cmd;
    logic           w_front_keep;

    // Command queue between the decoder and the update engine.
    logic           w_cmd_push;
    logic           w_cmd_empty;
    logic           w_cmd_pop;
    logic [$bits(idll_pkg::t_cmd)-1:0] w_cmd_q;
    idll_pkg::t_cmd w_cmd;

    // Result queue toward the consumer.
    logic           w_res_push;
    logic           w_res_full;
    idll_pkg::t_res w_res_in;
    logic [$bits(idll_pkg::t_res)-1:0] w_res_q;
    idll_pkg::t_res w_res_out;

    idll_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .i_req_type   (i_req_type),
        .i_node_index (i_node_index),
        .i_item_value (i_item_value),
        .i_link_next  (i_link_next),
        .i_link_prev  (i_link_prev),
        .i_head_index (i_head_index),
        .i_tail_index (i_tail_index),
        .i_free_start (i_free_start),
        .o_keep       (w_front_keep),
        .o_cmd        (w_front_cmd)
    );

    // Every accepted word leaves the port; only words with an effect are
    // queued for the engine. Unknown requests and loads of no node vanish
    // here and never produce a result.
    assign w_cmd_push = push && !full && w_front_keep;

    idll_fifo #(
        .WIDTH ($bits(idll_pkg::t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_q),
        .o_empty (w_cmd_empty)
    );

    assign w_cmd = w_cmd_q;

    // The engine starts a word only when the result queue has room, so a
    // result never has to wait inside the engine.
    idll_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    idll_fifo #(
        .WIDTH ($bits(idll_pkg::t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_q),
        .o_empty (empty)
    );

    // The oldest result word sits on the output ports while empty is low.
    assign w_res_out       = w_res_q;
    assign o_new_index     = w_res_out.new_index;
    assign o_removed_value = w_res_out.removed_value;
    assign o_status        = w_res_out.status;

endmodule

// ----- verif/indexed_doubly_linked_list_top_tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for the indexed doubly linked list
// Sends load, set-ends, insert, delete and unknown request words through the
// input queue, predicts each insert and delete answer with a local model of
// the node store, and compares every popped result word field by field.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES        = 1024;
    localparam int NONE         = -1;
    localparam int RAND_ITEMS   = 890;
    localparam int CALM_ITEMS   = 100;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_REPORTS  = 50;

    // Request codes 5 to 7 have no meaning and must be dropped silently.
    localparam logic [idll_pkg::REQ_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
    localparam logic [idll_pkg::REQ_W-1:0] OP_UNKNOWN_LAST  = 3'd7;

    // One request word as it is put on the input ports.
    typedef struct packed {
        logic [idll_pkg::REQ_W-1:0]         op;
        logic signed [idll_pkg::PIDX_W-1:0] node;
        logic [idll_pkg::VAL_W-1:0]         value;
        logic signed [idll_pkg::PIDX_W-1:0] lnext;
        logic signed [idll_pkg::PIDX_W-1:0] lprev;
        logic signed [idll_pkg::PIDX_W-1:0] head;
        logic signed [idll_pkg::PIDX_W-1:0] tail;
        logic [idll_pkg::PIDX_W-1:0]        free;
    } t_req;

    // A directed step: the request and, where it is obvious, its answer.
    typedef struct packed {
        t_req           rq;
        logic           typed;
        idll_pkg::t_res want;
    } t_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                push = 1'b0;
    logic                                full;
    logic [idll_pkg::REQ_W-1:0]          i_req_type = '0;
    logic signed [idll_pkg::PIDX_W-1:0]  i_node_index = '0;
    logic signed [idll_pkg::VAL_W-1:0]   i_item_value = '0;
    logic signed [idll_pkg::PIDX_W-1:0]  i_link_next = '0;
    logic signed [idll_pkg::PIDX_W-1:0]  i_link_prev = '0;
    logic signed [idll_pkg::PIDX_W-1:0]  i_head_index = '0;
    logic signed [idll_pkg::PIDX_W-1:0]  i_tail_index = '0;
    logic [idll_pkg::PIDX_W-1:0]         i_free_start = '0;
    logic                                empty;
    logic                                pop = 1'b0;
    logic [idll_pkg::IDX_W-1:0]          o_new_index;
    logic signed [idll_pkg::VAL_W-1:0]   o_removed_value;
    logic                                o_status;

    indexed_doubly_linked_list_top #(
        .NODE_COUNT(NODES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_node_index   (i_node_index),
        .i_item_value   (i_item_value),
        .i_link_next    (i_link_next),
        .i_link_prev    (i_link_prev),
        .i_head_index   (i_head_index),
        .i_tail_index   (i_tail_index),
        .i_free_start   (i_free_start),
        .empty          (empty),
        .pop            (pop),
        .o_new_index    (o_new_index),
        .o_removed_value(o_removed_value),
        .o_status       (o_status)
    );

    // Shadow copy of the node store and the list registers.
    logic [idll_pkg::VAL_W-1:0] shadow_value [NODES];
    int                         shadow_next  [NODES];
    int                         shadow_prev  [NODES];
    bit                         shadow_known [NODES];
    int                         list_head = NONE;
    int                         list_tail = NONE;
    int                         free_ptr  = 0;

    // Entries written so far, and the nodes reached by walking from the head.
    int             written_ids [$];
    int             linked_ids  [$];
    idll_pkg::t_res pending_results [$];

    bit calm = 1'b0;
    int mismatches = 0;
    int results_checked = 0;
    int cycle_count = 0;
    int n_inserts = 0;
    int n_full = 0;
    int n_deletes = 0;
    int n_loads = 0;
    int n_ends = 0;
    int n_ignored = 0;

    // Directed steps. They grow a short list from reset, take nodes off its
    // middle, head and tail, use indices out of range, fill the store through
    // a saturating free pointer, and finally restore a small valid list.
    t_row directed_rows [0:22] = '{
        '{'{idll_pkg::OP_INS_AFTER,  -1,    32'h7FFF_FFFF, -1, -1, -1, -1, 0}, 1'b1,
          '{10'd0, 32'd0, 1'b0}},
        '{'{idll_pkg::OP_INS_BEFORE, -1,    32'h8000_0000, -1, -1, -1, -1, 0}, 1'b1,
          '{10'd1, 32'd0, 1'b0}},
        '{'{idll_pkg::OP_INS_AFTER,  0,     32'h0000_0000, 0, 0, 0, 0, 0}, 1'b0, '0},
        '{'{idll_pkg::OP_INS_BEFORE, 1,     32'hFFFF_FFFF, 0, 0, 0, 0, 0}, 1'b0, '0},
        '{'{idll_pkg::OP_INS_AFTER,  -1024, 32'h1234_5678, 0, 0, 0, 0, 0}, 1'b0, '0},
        '{'{idll_pkg::OP_INS_BEFORE, -2,    32'h0000_FFFF, 0, 0, 0, 0, 0}, 1'b0, '0},
        '{'{idll_pkg::OP_DELETE,     0,     32'd0, 0, 0, 0, 0, 0}, 1'b1,
          '{10'd0, 32'h7FFF_FFFF, 1'b0}},
        '{'{idll_pkg::OP_DELETE,     4,     32'd0, 0, 0, 0, 0, 0}, 1'b1,
          '{10'd0, 32'h1234_5678, 1'b0}},
        '{'{idll_pkg::OP_DELETE,     5,     32'd0, 0, 0, 0, 0, 0}, 1'b0, '0},
        '{'{idll_pkg::OP_DELETE,     -1,    32'd0, 0, 0, 0, 0, 0}, 1'b1,
          '{10'd0, 32'd0, 1'b0}},
        '{'{idll_pkg::OP_DELETE,     -700,  32'd0, 0, 0, 0, 0, 0}, 1'b1,
          '{10'd0, 32'd0, 1'b0}},
        '{'{idll_pkg::OP_LOAD,       1022,  32'd5, 1023, -1024, 0, 0, 0}, 1'b0, '0},
        '{'{idll_pkg::OP_LOAD,       1023,  32'h8000_0001, -1, 1022, 0, 0, 0}, 1'b0, '0},
        '{'{idll_pkg::OP_LOAD,       -1,    32'hFFFF_FFFF, -1, -1, -1, -1, 2047}, 1'b0, '0},
        '{'{OP_UNKNOWN_FIRST, -1, 32'hFFFF_FFFF, -1, -1, -1, -1, 2047}, 1'b0, '0},
        '{'{idll_pkg::OP_ENDS,       0,     32'd0, 0, 0, 1022, 1023, 2047}, 1'b0, '0},
        '{'{idll_pkg::OP_INS_AFTER,  1022,  32'd7, 0, 0, 0, 0, 0}, 1'b1,
          '{10'd0, 32'd0, 1'b1}},
        '{'{idll_pkg::OP_INS_BEFORE, -1,    32'd9, 0, 0, 0, 0, 0}, 1'b1,
          '{10'd0, 32'd0, 1'b1}},
        '{'{idll_pkg::OP_DELETE,     1022,  32'd0, 0, 0, 0, 0, 0}, 1'b1,
          '{10'd0, 32'd5, 1'b0}},
        '{'{idll_pkg::OP_ENDS,       0,     32'd0, 0, 0, 1023, 1023, 1020}, 1'b0, '0},
        '{'{idll_pkg::OP_INS_BEFORE, 1023,  32'h5A5A_5A5A, 0, 0, 0, 0, 0}, 1'b0, '0},
        '{'{idll_pkg::OP_ENDS,       0,     32'd0, 0, 0, 2, 1, 6}, 1'b0, '0},
        '{'{OP_UNKNOWN_LAST, 0,   32'd0, 0, 0, 0, 0, 0}, 1'b0, '0}
    };

    // Free-running clock with a 12 ns period.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Any index that is negative or past the store means no node.
    function automatic int map_index(input logic signed [idll_pkg::PIDX_W-1:0] raw);
        return (raw < 0 || raw >= NODES) ? NONE : int'(raw);
    endfunction

    function automatic void put_entry(input int at, input logic [idll_pkg::VAL_W-1:0] val,
                                      input int nx, input int pv);
        shadow_value[at] = val;
        shadow_next[at]  = nx;
        shadow_prev[at]  = pv;
        if (!shadow_known[at]) begin
            shadow_known[at] = 1'b1;
            written_ids.push_back(at);
        end
    endfunction

    // Applies one accepted word to the shadow store. Returns 1 when the word
    // produces a result word, which is then left in res. Links are followed
    // exactly as stored, in the same order the hardware reads them.
    function automatic bit predict_list_op(input t_req r, output idll_pkg::t_res res);
        int a;
        int n;
        logic [idll_pkg::VAL_W-1:0] gone;
        a = map_index(r.node);
        res = '0;
        predict_list_op = 1'b0;
        case (r.op)
            idll_pkg::OP_LOAD: begin
                if (a != NONE)
                    put_entry(a, r.value, map_index(r.lnext), map_index(r.lprev));
            end
            idll_pkg::OP_ENDS: begin
                list_head = map_index(r.head);
                list_tail = map_index(r.tail);
                free_ptr  = (r.free > NODES) ? NODES : int'(r.free);
            end
            idll_pkg::OP_INS_AFTER, idll_pkg::OP_INS_BEFORE: begin
                predict_list_op = 1'b1;
                if (free_ptr >= NODES) begin
                    res.status = 1'b1;
                end else begin
                    n = free_ptr;
                    free_ptr++;
                    put_entry(n, r.value, NONE, NONE);
                    if (r.op == idll_pkg::OP_INS_AFTER) begin
                        if (a == NONE) begin
                            shadow_next[n] = list_head;
                            if (list_head != NONE)
                                shadow_prev[list_head] = n;
                            list_head = n;
                            if (list_tail == NONE)
                                list_tail = n;
                        end else begin
                            shadow_next[n] = shadow_next[a];
                            shadow_prev[n] = a;
                            if (shadow_next[a] != NONE)
                                shadow_prev[shadow_next[a]] = n;
                            else
                                list_tail = n;
                            shadow_next[a] = n;
                        end
                    end else begin
                        if (a == NONE) begin
                            shadow_prev[n] = list_tail;
                            if (list_tail != NONE)
                                shadow_next[list_tail] = n;
                            list_tail = n;
                            if (list_head == NONE)
                                list_head = n;
                        end else begin
                            shadow_prev[n] = shadow_prev[a];
                            shadow_next[n] = a;
                            if (shadow_prev[a] != NONE)
                                shadow_next[shadow_prev[a]] = n;
                            else
                                list_head = n;
                            shadow_prev[a] = n;
                        end
                    end
                    res.new_index = idll_pkg::IDX_W'(n);
                end
            end
            idll_pkg::OP_DELETE: begin
                predict_list_op = 1'b1;
                if (a != NONE) begin
                    gone = shadow_value[a];
                    if (shadow_prev[a] != NONE)
                        shadow_next[shadow_prev[a]] = shadow_next[a];
                    else
                        list_head = shadow_next[a];
                    if (shadow_next[a] != NONE)
                        shadow_prev[shadow_next[a]] = shadow_prev[a];
                    else
                        list_tail = shadow_prev[a];
                    res.removed_value = gone;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic bit usable(input int x, input int fresh);
        return x == NONE || x == fresh || shadow_known[x];
    endfunction

    // Returns an entry that the word would read or patch while it was never
    // written, or NONE when the word stays inside written entries.
    function automatic int first_unwritten(input t_req r);
        int a;
        int n;
        int hop;
        int end_ptr;
        a = map_index(r.node);
        n = (free_ptr < NODES) ? free_ptr : NONE;
        end_ptr = (r.op == idll_pkg::OP_INS_AFTER) ? list_head : list_tail;
        case (r.op)
            idll_pkg::OP_INS_AFTER, idll_pkg::OP_INS_BEFORE: begin
                if (n == NONE)
                    return NONE;
                if (a == NONE)
                    return usable(end_ptr, n) ? NONE : end_ptr;
                if (!usable(a, n))
                    return a;
                // A fresh node used as its own anchor has just lost its links.
                if (a == n)
                    hop = NONE;
                else
                    hop = (r.op == idll_pkg::OP_INS_AFTER) ? shadow_next[a] : shadow_prev[a];
                return usable(hop, n) ? NONE : hop;
            end
            idll_pkg::OP_DELETE: begin
                if (a == NONE)
                    return NONE;
                if (!shadow_known[a])
                    return a;
                if (!usable(shadow_prev[a], NONE))
                    return shadow_prev[a];
                if (!usable(shadow_next[a], NONE))
                    return shadow_next[a];
                return NONE;
            end
            default: return NONE;
        endcase
    endfunction

    function automatic logic [idll_pkg::VAL_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [idll_pkg::REQ_W-1:0] pick_unknown_op();
        return idll_pkg::REQ_W'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
    endfunction

    function automatic int pick_written();
        if (written_ids.size() == 0)
            return NONE;
        return written_ids[$urandom_range(0, written_ids.size() - 1)];
    endfunction

    // Mostly a node that is on the list, sometimes a list end given as -1 or
    // as an out-of-range value, sometimes any written entry.
    function automatic logic signed [idll_pkg::PIDX_W-1:0] pick_anchor();
        int c;
        c = $urandom_range(0, 9);
        if (c < 7 && linked_ids.size() != 0)
            return idll_pkg::PIDX_W'(linked_ids[$urandom_range(0, linked_ids.size() - 1)]);
        if (c == 7)
            return idll_pkg::PIDX_W'(NONE);
        if (c == 8)
            return idll_pkg::PIDX_W'(-int'($urandom_range(2, NODES)));
        return idll_pkg::PIDX_W'(pick_written());
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    // Puts one word on the input side, holds it until the queue takes it and
    // then books the answer it must produce. A gap may come before the word.
    task automatic send_word(input t_req r, input logic typed, input idll_pkg::t_res want);
        idll_pkg::t_res got;
        if (!calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_req_type   <= r.op;
        i_node_index <= r.node;
        i_item_value <= r.value;
        i_link_next  <= r.lnext;
        i_link_prev  <= r.lprev;
        i_head_index <= r.head;
        i_tail_index <= r.tail;
        i_free_start <= r.free;
        do @(posedge i_clk); while (full);
        if (predict_list_op(r, got))
            pending_results.push_back(typed ? want : got);
        case (r.op)
            idll_pkg::OP_INS_AFTER, idll_pkg::OP_INS_BEFORE: begin
                n_inserts++;
                if (got.status)
                    n_full++;
            end
            idll_pkg::OP_DELETE: n_deletes++;
            idll_pkg::OP_LOAD:   n_loads++;
            idll_pkg::OP_ENDS:   n_ends++;
            default:             n_ignored++;
        endcase
    endtask

    // Result side: pop is raised most of the time, with random stall bursts
    // until the calm tail of the run.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 10) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Every popped word is checked against the oldest booked answer. Values
    // are sampled at the edge, before the block updates its outputs.
    always @(posedge i_clk) begin
        idll_pkg::t_res want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word with nothing pending: %0d %h %0b",
                                          o_new_index, o_removed_value, o_status));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_new_index !== want.new_index)
                    report_mismatch($sformatf("new_index %0d, expected %0d",
                                              o_new_index, want.new_index));
                if (o_removed_value !== want.removed_value)
                    report_mismatch($sformatf("removed_value %h, expected %h",
                                              o_removed_value, want.removed_value));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0b, expected %0b",
                                              o_status, want.status));
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d result words still due.",
                 cycle_count, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus: reset, the directed steps, then random traffic.
    initial begin
        t_req r;
        int   k;
        int   sel;
        int   bad;
        int   p;
        int   steps;
        int   saved_free;
        saved_free = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

        k = 0;
        while (k < RAND_ITEMS) begin
            calm = (k >= RAND_ITEMS - CALM_ITEMS);

            // Nodes currently reachable from the head; the walk is bounded
            // because deliberately broken links may form a loop.
            linked_ids.delete();
            p = list_head;
            steps = 0;
            while (p != NONE && shadow_known[p] && steps < NODES) begin
                linked_ids.push_back(p);
                p = shadow_next[p];
                steps++;
            end

            // Unused fields carry noise so that every port bit toggles.
            r.node  = idll_pkg::PIDX_W'($urandom);
            r.value = random_value();
            r.lnext = idll_pkg::PIDX_W'($urandom);
            r.lprev = idll_pkg::PIDX_W'($urandom);
            r.head  = idll_pkg::PIDX_W'($urandom);
            r.tail  = idll_pkg::PIDX_W'($urandom);
            r.free  = idll_pkg::PIDX_W'($urandom);

            sel = $urandom_range(0, 99);
            if (sel < 38) begin
                r.op   = idll_pkg::OP_INS_AFTER;
                r.node = pick_anchor();
            end else if (sel < 66) begin
                r.op   = idll_pkg::OP_INS_BEFORE;
                r.node = pick_anchor();
            end else if (sel < 86) begin
                r.op   = idll_pkg::OP_DELETE;
                r.node = pick_anchor();
            end else if (sel < 92) begin
                // Loads land mostly in the unused area so the list survives.
                r.op = idll_pkg::OP_LOAD;
                if (free_ptr < NODES && $urandom_range(0, 1) == 0)
                    r.node = idll_pkg::PIDX_W'($urandom_range(free_ptr, NODES - 1));
                r.lnext = pick_anchor();
                r.lprev = pick_anchor();
            end else if (sel < 96) begin
                // Set-ends either leaves or enters a full-store episode, or
                // now and then moves the ends somewhere arbitrary.
                r.op   = idll_pkg::OP_ENDS;
                r.head = idll_pkg::PIDX_W'(list_head);
                r.tail = idll_pkg::PIDX_W'(list_tail);
                if (free_ptr >= NODES) begin
                    r.free = idll_pkg::PIDX_W'(saved_free);
                end else if ($urandom_range(0, 3) == 0) begin
                    saved_free = free_ptr;
                    r.free = idll_pkg::PIDX_W'($urandom_range(NODES, 2047));
                end else begin
                    r.free = idll_pkg::PIDX_W'(free_ptr);
                    if ($urandom_range(0, 3) == 0) begin
                        r.head = pick_anchor();
                        r.tail = pick_anchor();
                    end
                end
            end else begin
                r.op = pick_unknown_op();
            end

            // A word that would touch a never-written entry becomes a load of
            // that entry instead.
            bad = first_unwritten(r);
            if (bad != NONE) begin
                r.op    = idll_pkg::OP_LOAD;
                r.node  = idll_pkg::PIDX_W'(bad);
                r.lnext = pick_anchor();
                r.lprev = pick_anchor();
            end

            send_word(r, 1'b0, '0);
            if (r.op < OP_UNKNOWN_FIRST)
                k++;
        end
        push <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d inserts (%0d into a full store), %0d deletes, %0d loads,",
                 n_inserts, n_full, n_deletes, n_loads);
        $display("%0d end updates and %0d unknown codes; %0d results checked, %0d mismatches.",
                 n_ends, n_ignored, results_checked, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
